// ===== rtl/pcr_pkg.sv =====
// shared constants, types and helpers of the particle contact resolver
package pcr_pkg;

   localparam int CW        = 21;
   localparam int VW        = 3 * CW;
   localparam int FIELD_W   = 63;
   localparam int FRAC      = 10;
   localparam int INV_W     = 24;
   localparam int DENW      = INV_W + 1;
   localparam int DEPTH_W   = 21;
   localparam int BOUNCE_W  = 16;
   localparam int STEP_W    = 16;
   localparam logic [STEP_W-1:0] STEP_RESET = 16'd1092;

   localparam int DW        = CW + 1;
   localparam int PW        = DW + CW;
   localparam int SW        = PW + 2;
   localparam int AMW       = SW + STEP_W + 1;
   localparam int NSW       = SW + BOUNCE_W + 2;
   localparam int QB        = SW - FRAC + 4;
   localparam int NUMW      = QB + INV_W;
   localparam int MW        = CW + QB + 2;
   localparam int SATW      = MW + 1;
   localparam int COMP_MAX  = 2 ** (CW - 1) - 1;
   localparam int COMP_MIN  = -(2 ** (CW - 1));

   typedef logic signed [CW-1:0] comp_type;

   function automatic comp_type get_comp(input logic [VW-1:0] v, input int c);
      return v[c*CW +: CW];
   endfunction

   function automatic comp_type sat_comp(input logic signed [SATW-1:0] x);
      logic signed [SATW-1:0] hi;
      logic signed [SATW-1:0] lo;
      hi = SATW'(COMP_MAX);
      lo = SATW'(COMP_MIN);
      if (x > hi) begin
         return CW'(hi);
      end else if (x < lo) begin
         return CW'(lo);
      end
      return CW'(x);
   endfunction

endpackage

// ===== rtl/pcr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module pcr_div import pcr_pkg::*; (
   input  logic            clock,
   input  logic [NUMW-1:0] num,
   input  logic [DENW-1:0] den,
   output logic [QB-1:0]   quo,
   output logic            rem_nz
);

   logic [DENW-1:0] rem_ff   [0:QB];
   logic [QB-1:0]   low_ff   [0:QB];
   logic [QB-1:0]   quo_ff   [0:QB];
   logic [DENW-1:0] den_ff   [0:QB];
   logic [DENW:0]   trial    [0:QB-1];
   logic [DENW-1:0] rem_in   [0:QB-1];
   logic            qbit_in  [0:QB-1];

   always_comb begin
      for (int i = 0; i < QB; i++) begin
         trial[i] = {rem_ff[i], low_ff[i][QB-1]};
         if (trial[i] >= {1'b0, den_ff[i]}) begin
            rem_in[i]  = DENW'(trial[i] - {1'b0, den_ff[i]});
            qbit_in[i] = 1'b1;
         end else begin
            rem_in[i]  = DENW'(trial[i]);
            qbit_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= DENW'(num[NUMW-1:QB]);
      low_ff[0] <= num[QB-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= den;
      for (int i = 0; i < QB; i++) begin
         rem_ff[i+1] <= rem_in[i];
         low_ff[i+1] <= {low_ff[i][QB-2:0], 1'b0};
         quo_ff[i+1] <= {quo_ff[i][QB-2:0], qbit_in[i]};
         den_ff[i+1] <= den_ff[i];
      end
   end

   assign quo    = quo_ff[QB];
   assign rem_nz = |rem_ff[QB];

endmodule

// ===== rtl/particle_contact_resolver.sv =====
// top level of the particle contact resolver pipeline
//
//  channel  direction  handshake               beat
//  req_*    in         start high, busy low    one contact
//  rsp_*    out        rsp_strobe, one cycle   one resolved contact
//  csr_*    in         csr_valid and csr_ready frame step
//
// one contact enters per cycle; each result passes through the
// bit-per-stage dividers
// busy and csr_ready are constant, nothing ever stalls
// synchronous reset clears valid bits and restores the frame step
module particle_contact_resolver import pcr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FIELD_W-1:0]  req_first_velocity,
   input  logic [FIELD_W-1:0]  req_second_velocity,
   input  logic [FIELD_W-1:0]  req_first_accel,
   input  logic [FIELD_W-1:0]  req_second_accel,
   input  logic [FIELD_W-1:0]  req_first_position,
   input  logic [FIELD_W-1:0]  req_second_position,
   input  logic [FIELD_W-1:0]  req_normal,
   input  logic [INV_W-1:0]    req_first_inv_mass,
   input  logic [INV_W-1:0]    req_second_inv_mass,
   input  logic signed [DEPTH_W-1:0] req_depth,
   input  logic [BOUNCE_W-1:0] req_bounce,
   input  logic                req_second_present,
   output logic                rsp_strobe,
   output logic [FIELD_W-1:0]  rsp_new_first_velocity,
   output logic [FIELD_W-1:0]  rsp_new_second_velocity,
   output logic [FIELD_W-1:0]  rsp_new_first_position,
   output logic [FIELD_W-1:0]  rsp_new_second_position,
   output logic                rsp_velocity_changed,
   output logic                rsp_position_changed,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [STEP_W-1:0]   csr_frame_step
);

   localparam int FS = 9;

   typedef struct packed {
      logic                       present;
      logic [VW-1:0]              n;
      logic [VW-1:0]              v1;
      logic [VW-1:0]              v2;
      logic [VW-1:0]              p1;
      logic [VW-1:0]              p2;
      logic [INV_W-1:0]           inv1;
      logic [DENW-1:0]            tot;
      logic signed [DEPTH_W-1:0]  depth;
      logic [BOUNCE_W-1:0]        bounce;
   } front_type;

   typedef struct packed {
      logic          vflag;
      logic          pflag;
      logic          present;
      logic [VW-1:0] n;
      logic [VW-1:0] v1;
      logic [VW-1:0] v2;
      logic [VW-1:0] p1;
      logic [VW-1:0] p2;
      logic [QB-1:0] d10;
      logic [QB-1:0] dep;
   } pay_type;

   logic [STEP_W-1:0]      frame_step_ff;
   logic                   vld_ff [1:FS];
   front_type              f_ff   [1:FS];
   front_type              f_in;

   logic signed [DW-1:0]   dvel_ff [0:2];
   logic signed [DW-1:0]   dacc_ff [0:2];
   logic signed [PW-1:0]   pvel_ff [0:2];
   logic signed [PW-1:0]   pacc_ff [0:2];
   logic signed [SW-1:0]   sep3_ff, adot3_ff;
   logic signed [SW-1:0]   sep4_ff, sep5_ff, sep6_ff, sep7_ff;
   logic signed [AMW-1:0]  accm4_ff;
   logic signed [NSW-1:0]  nsb4_ff, nsb5_ff, nsb6_ff;
   logic signed [SW-1:0]   acc5_ff;
   logic signed [NSW-1:0]  bacc6_ff;
   logic                   accneg6_ff;
   logic signed [NSW-1:0]  ns7_ff, ns7_in;
   logic signed [NSW:0]    t8;
   logic [QB-1:0]          d10_8_ff, d10_9_ff;
   logic                   vflag8_ff, vflag9_ff, pflag9_ff;
   logic [NUMW-1:0]        numv9_ff, nump9_ff;
   logic [QB-1:0]          dep9_ff;

   logic [QB-1:0]          qv, qp;
   logic                   nzv, nzp;

   pay_type                pay_ff [0:QB];
   logic                   pvld_ff [0:QB];
   pay_type                pa_ff, pb_ff;
   logic                   pa_vld_ff, pb_vld_ff;
   logic [QB-1:0]          dv1_ff, dv2_ff, mv1_ff, mv2_ff;
   logic signed [MW-1:0]   pr_ff [0:3][0:2];

   logic [VW-1:0]          nv1_in, nv2_in, np1_in, np2_in;
   logic [VW-1:0]          nv1_ff, nv2_ff, np1_ff, np2_ff;
   logic                   strobe_ff, vch_ff, pch_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_step_ff <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         frame_step_ff <= csr_frame_step;
      end
   end

   // stage 1: capture and relative vectors
   always_comb begin
      f_in.present = req_second_present;
      f_in.n       = req_normal[VW-1:0];
      f_in.v1      = req_first_velocity[VW-1:0];
      f_in.v2      = req_second_velocity[VW-1:0];
      f_in.p1      = req_first_position[VW-1:0];
      f_in.p2      = req_second_position[VW-1:0];
      f_in.inv1    = req_first_inv_mass;
      f_in.tot     = DENW'(req_first_inv_mass) +
                     (req_second_present ? DENW'(req_second_inv_mass) : DENW'(0));
      f_in.depth   = req_depth;
      f_in.bounce  = req_bounce;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= FS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[1] <= start && !busy;
         for (int i = 2; i <= FS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      f_ff[1] <= f_in;
      for (int i = 2; i <= FS; i++) begin
         f_ff[i] <= f_ff[i-1];
      end
      for (int c = 0; c < 3; c++) begin
         dvel_ff[c] <= DW'(get_comp(req_first_velocity[VW-1:0], c)) -
                       (req_second_present ?
                        DW'(get_comp(req_second_velocity[VW-1:0], c)) : DW'(0));
         dacc_ff[c] <= DW'(get_comp(req_first_accel[VW-1:0], c)) -
                       (req_second_present ?
                        DW'(get_comp(req_second_accel[VW-1:0], c)) : DW'(0));
      end
   end

   // stages 2 to 3: dot products
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         pvel_ff[c] <= PW'(dvel_ff[c]) * PW'(get_comp(f_ff[1].n, c));
         pacc_ff[c] <= PW'(dacc_ff[c]) * PW'(get_comp(f_ff[1].n, c));
      end
      sep3_ff  <= SW'(pvel_ff[0]) + SW'(pvel_ff[1]) + SW'(pvel_ff[2]);
      adot3_ff <= SW'(pacc_ff[0]) + SW'(pacc_ff[1]) + SW'(pacc_ff[2]);
   end

   // stages 4 to 8: restitution and closing velocity
   always_comb begin
      ns7_in = nsb6_ff + (accneg6_ff ? bacc6_ff : NSW'(0));
      if (accneg6_ff && ns7_in < 0) begin
         ns7_in = '0;
      end
      t8 = (NSW+1)'(ns7_ff >>> 15) - (NSW+1)'(sep7_ff);
   end

   always_ff @(posedge clock) begin
      sep4_ff    <= sep3_ff;
      accm4_ff   <= AMW'(adot3_ff) * AMW'($signed({1'b0, frame_step_ff}));
      nsb4_ff    <= -(NSW'(sep3_ff)) * NSW'($signed({1'b0, f_ff[3].bounce}));
      sep5_ff    <= sep4_ff;
      nsb5_ff    <= nsb4_ff;
      acc5_ff    <= SW'(accm4_ff >>> 16);
      sep6_ff    <= sep5_ff;
      nsb6_ff    <= nsb5_ff;
      accneg6_ff <= acc5_ff < 0;
      bacc6_ff   <= NSW'(acc5_ff) * NSW'($signed({1'b0, f_ff[5].bounce}));
      sep7_ff    <= sep6_ff;
      ns7_ff     <= ns7_in;
      d10_8_ff   <= QB'(t8 >>> FRAC);
      vflag8_ff  <= (sep7_ff <= 0) && (f_ff[7].tot != '0);
   end

   // stage 9: divider numerators
   always_ff @(posedge clock) begin
      numv9_ff  <= NUMW'(d10_8_ff) * NUMW'(f_ff[8].inv1);
      if (f_ff[8].depth > 0) begin
         nump9_ff <= NUMW'($unsigned(f_ff[8].depth)) * NUMW'(f_ff[8].inv1);
         dep9_ff  <= QB'($unsigned(f_ff[8].depth));
      end else begin
         nump9_ff <= '0;
         dep9_ff  <= '0;
      end
      d10_9_ff  <= d10_8_ff;
      vflag9_ff <= vflag8_ff;
      pflag9_ff <= (f_ff[8].depth > 0) && (f_ff[8].tot != '0);
   end

   pcr_div u_div_vel (
      .clock  (clock),
      .num    (numv9_ff),
      .den    (f_ff[FS].tot),
      .quo    (qv),
      .rem_nz (nzv)
   );

   pcr_div u_div_pos (
      .clock  (clock),
      .num    (nump9_ff),
      .den    (f_ff[FS].tot),
      .quo    (qp),
      .rem_nz (nzp)
   );

   // side payload alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QB; i++) begin
            pvld_ff[i] <= 1'b0;
         end
         pa_vld_ff <= 1'b0;
         pb_vld_ff <= 1'b0;
      end else begin
         pvld_ff[0] <= vld_ff[FS];
         for (int i = 1; i <= QB; i++) begin
            pvld_ff[i] <= pvld_ff[i-1];
         end
         pa_vld_ff <= pvld_ff[QB];
         pb_vld_ff <= pa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff[0].vflag   <= vflag9_ff;
      pay_ff[0].pflag   <= pflag9_ff;
      pay_ff[0].present <= f_ff[FS].present;
      pay_ff[0].n       <= f_ff[FS].n;
      pay_ff[0].v1      <= f_ff[FS].v1;
      pay_ff[0].v2      <= f_ff[FS].v2;
      pay_ff[0].p1      <= f_ff[FS].p1;
      pay_ff[0].p2      <= f_ff[FS].p2;
      pay_ff[0].d10     <= d10_9_ff;
      pay_ff[0].dep     <= dep9_ff;
      for (int i = 1; i <= QB; i++) begin
         pay_ff[i] <= pay_ff[i-1];
      end
   end

   // share of the second particle from the first one's remainder
   always_ff @(posedge clock) begin
      pa_ff  <= pay_ff[QB];
      dv1_ff <= qv;
      dv2_ff <= pay_ff[QB].d10 - qv - QB'(nzv);
      mv1_ff <= qp;
      mv2_ff <= pay_ff[QB].dep - qp - QB'(nzp);
   end

   // per-component deltas along the normal
   always_ff @(posedge clock) begin
      pb_ff <= pa_ff;
      for (int c = 0; c < 3; c++) begin
         pr_ff[0][c] <= MW'(get_comp(pa_ff.n, c)) * MW'($signed({1'b0, dv1_ff}));
         pr_ff[1][c] <= -(MW'(get_comp(pa_ff.n, c)) * MW'($signed({1'b0, dv2_ff})));
         pr_ff[2][c] <= MW'(get_comp(pa_ff.n, c)) * MW'($signed({1'b0, mv1_ff}));
         pr_ff[3][c] <= -(MW'(get_comp(pa_ff.n, c)) * MW'($signed({1'b0, mv2_ff})));
      end
   end

   // apply, saturate, select pass-through
   always_comb begin
      nv1_in = pb_ff.v1;
      nv2_in = pb_ff.v2;
      np1_in = pb_ff.p1;
      np2_in = pb_ff.p2;
      for (int c = 0; c < 3; c++) begin
         if (pb_ff.vflag) begin
            nv1_in[c*CW +: CW] = sat_comp(SATW'(get_comp(pb_ff.v1, c)) +
                                          SATW'(pr_ff[0][c] >>> FRAC));
            if (pb_ff.present) begin
               nv2_in[c*CW +: CW] = sat_comp(SATW'(get_comp(pb_ff.v2, c)) +
                                             SATW'(pr_ff[1][c] >>> FRAC));
            end
         end
         if (pb_ff.pflag) begin
            np1_in[c*CW +: CW] = sat_comp(SATW'(get_comp(pb_ff.p1, c)) +
                                          SATW'(pr_ff[2][c] >>> FRAC));
            if (pb_ff.present) begin
               np2_in[c*CW +: CW] = sat_comp(SATW'(get_comp(pb_ff.p2, c)) +
                                             SATW'(pr_ff[3][c] >>> FRAC));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= pb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      nv1_ff <= nv1_in;
      nv2_ff <= nv2_in;
      np1_ff <= np1_in;
      np2_ff <= np2_in;
      vch_ff <= pb_ff.vflag;
      pch_ff <= pb_ff.pflag;
   end

   assign rsp_strobe              = strobe_ff;
   assign rsp_new_first_velocity  = FIELD_W'(nv1_ff);
   assign rsp_new_second_velocity = FIELD_W'(nv2_ff);
   assign rsp_new_first_position  = FIELD_W'(np1_ff);
   assign rsp_new_second_position = FIELD_W'(np2_ff);
   assign rsp_velocity_changed    = vch_ff;
   assign rsp_position_changed    = pch_ff;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the particle contact resolver
module tb import pcr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [FIELD_W-1:0] v1, v2, a1, a2, p1, p2, n;
      logic [INV_W-1:0] inv1, inv2;
      logic signed [DEPTH_W-1:0] depth;
      logic [BOUNCE_W-1:0] bounce;
      logic present;
   } contact_type;

   typedef struct {
      logic [FIELD_W-1:0] nv1, nv2, np1, np2;
      logic vchg, pchg;
   } resolved_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [FIELD_W-1:0] req_first_velocity = '0, req_second_velocity = '0;
   logic [FIELD_W-1:0] req_first_accel = '0, req_second_accel = '0;
   logic [FIELD_W-1:0] req_first_position = '0, req_second_position = '0;
   logic [FIELD_W-1:0] req_normal = '0;
   logic [INV_W-1:0] req_first_inv_mass = '0, req_second_inv_mass = '0;
   logic signed [DEPTH_W-1:0] req_depth = '0;
   logic [BOUNCE_W-1:0] req_bounce = '0;
   logic req_second_present = 0;
   logic rsp_strobe;
   logic [FIELD_W-1:0] rsp_new_first_velocity, rsp_new_second_velocity;
   logic [FIELD_W-1:0] rsp_new_first_position, rsp_new_second_position;
   logic rsp_velocity_changed, rsp_position_changed;
   logic csr_valid = 0;
   logic csr_ready;
   logic [STEP_W-1:0] csr_frame_step = '0;

   particle_contact_resolver DUT (.*);

   always #10 clock = ~clock;

   contact_type pending_contacts[$];
   resolved_type expected_results[$];
   logic [STEP_W-1:0] frame_step_model = STEP_RESET;
   int errors = 0;
   int results_seen = 0;
   int vel_hits = 0;
   int pos_hits = 0;
   int gap_left = 0;
   logic hold_off = 0;

   function automatic longint comp_of(logic [FIELD_W-1:0] f, int c);
      logic signed [CW-1:0] x;
      x = f[c*CW +: CW];
      return longint'(x);
   endfunction

   function automatic longint fdiv(longint x, longint d);
      longint q;
      q = x / d;
      if ((x % d) != 0 && x < 0) q -= 1;
      return q;
   endfunction

   function automatic logic [FIELD_W-1:0] pack_clamped(longint v[3]);
      logic [FIELD_W-1:0] r;
      longint x;
      r = '0;
      for (int c = 0; c < 3; c++) begin
         x = v[c];
         if (x > COMP_MAX) x = COMP_MAX;
         if (x < COMP_MIN) x = COMP_MIN;
         r[c*CW +: CW] = x[CW-1:0];
      end
      return r;
   endfunction

   function automatic resolved_type resolve_contact(contact_type t, logic [STEP_W-1:0] step);
      resolved_type r;
      longint v1[3], v2[3], a1[3], a2[3], p1[3], p2[3], n[3];
      longint nv1[3], nv2[3], np1[3], np2[3];
      longint inv1, inv2, total, dep, bnc, sep, accdot, acc, ns, d10, dv1, dv2, mv1, mv2;
      inv1 = t.inv1;
      inv2 = t.present ? longint'(t.inv2) : 0;
      total = inv1 + inv2;
      dep = t.depth;
      bnc = t.bounce;
      sep = 0;
      accdot = 0;
      for (int c = 0; c < 3; c++) begin
         v1[c] = comp_of(t.v1, c);
         v2[c] = t.present ? comp_of(t.v2, c) : 0;
         a1[c] = comp_of(t.a1, c);
         a2[c] = t.present ? comp_of(t.a2, c) : 0;
         p1[c] = comp_of(t.p1, c);
         p2[c] = comp_of(t.p2, c);
         n[c] = comp_of(t.n, c);
         sep += (v1[c] - v2[c]) * n[c];
         accdot += (a1[c] - a2[c]) * n[c];
         nv1[c] = v1[c]; nv2[c] = v2[c]; np1[c] = p1[c]; np2[c] = p2[c];
      end
      r.vchg = 0;
      r.pchg = 0;
      if (sep <= 0 && total > 0) begin
         acc = (accdot * longint'(step)) >>> 16;
         ns = (-sep) * bnc;
         if (acc < 0) begin
            ns += bnc * acc;
            if (ns < 0) ns = 0;
         end
         d10 = ((ns >>> 15) - sep) >>> 10;
         dv1 = fdiv(d10 * inv1, total);
         dv2 = fdiv(d10 * inv2, total);
         for (int c = 0; c < 3; c++) begin
            nv1[c] = v1[c] + ((n[c] * dv1) >>> 10);
            nv2[c] = v2[c] + ((-(n[c] * dv2)) >>> 10);
         end
         r.vchg = 1;
      end
      if (dep > 0 && total > 0) begin
         mv1 = fdiv(dep * inv1, total);
         mv2 = fdiv(dep * inv2, total);
         for (int c = 0; c < 3; c++) begin
            np1[c] = p1[c] + ((n[c] * mv1) >>> 10);
            np2[c] = p2[c] + ((-(n[c] * mv2)) >>> 10);
         end
         r.pchg = 1;
      end
      r.nv1 = pack_clamped(nv1);
      r.np1 = pack_clamped(np1);
      r.nv2 = t.present ? pack_clamped(nv2) : FIELD_W'(t.v2[VW-1:0]);
      r.np2 = t.present ? pack_clamped(np2) : FIELD_W'(t.p2[VW-1:0]);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      contact_type t;
      if (reset) begin
         start <= 0;
      end else if (start && !busy) begin
         expected_results.push_back(resolve_contact(pending_contacts.pop_front(),
                                                    frame_step_model));
         if (pending_contacts.size() != 0 && !hold_off && pick_gap() == 0) begin
            t = pending_contacts[0];
            req_first_velocity <= t.v1; req_second_velocity <= t.v2;
            req_first_accel <= t.a1; req_second_accel <= t.a2;
            req_first_position <= t.p1; req_second_position <= t.p2;
            req_normal <= t.n; req_first_inv_mass <= t.inv1;
            req_second_inv_mass <= t.inv2; req_depth <= t.depth;
            req_bounce <= t.bounce; req_second_present <= t.present;
            start <= 1;
            gap_left <= 0;
         end else begin
            start <= 0;
            gap_left <= pick_gap();
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_contacts.size() != 0 && !hold_off) begin
            t = pending_contacts[0];
            req_first_velocity <= t.v1; req_second_velocity <= t.v2;
            req_first_accel <= t.a1; req_second_accel <= t.a2;
            req_first_position <= t.p1; req_second_position <= t.p2;
            req_normal <= t.n; req_first_inv_mass <= t.inv1;
            req_second_inv_mass <= t.inv2; req_depth <= t.depth;
            req_bounce <= t.bounce; req_second_present <= t.present;
            start <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      resolved_type e;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_new_first_velocity, '0);
         end else begin
            e = expected_results.pop_front();
            vel_hits += e.vchg;
            pos_hits += e.pchg;
            if (rsp_new_first_velocity !== e.nv1)
               report_mismatch("new_first_velocity", rsp_new_first_velocity, e.nv1);
            if (rsp_new_second_velocity !== e.nv2)
               report_mismatch("new_second_velocity", rsp_new_second_velocity, e.nv2);
            if (rsp_new_first_position !== e.np1)
               report_mismatch("new_first_position", rsp_new_first_position, e.np1);
            if (rsp_new_second_position !== e.np2)
               report_mismatch("new_second_position", rsp_new_second_position, e.np2);
            if (rsp_velocity_changed !== e.vchg)
               report_mismatch("velocity_changed", FIELD_W'(rsp_velocity_changed),
                               FIELD_W'(e.vchg));
            if (rsp_position_changed !== e.pchg)
               report_mismatch("position_changed", FIELD_W'(rsp_position_changed),
                               FIELD_W'(e.pchg));
         end
      end
   end

   function automatic logic [FIELD_W-1:0] rand_vec(int mode);
      logic [FIELD_W-1:0] r;
      longint x;
      r = FIELD_W'({$urandom, $urandom});
      for (int c = 0; c < 3; c++) begin
         case (mode)
            0: x = $urandom_range(0, 4000) - 2000;
            1: x = $urandom_range(0, 2048) - 1024;
            default: x = comp_of(r, c);
         endcase
         if (mode != 2) r[c*CW +: CW] = x[CW-1:0];
      end
      return r;
   endfunction

   function automatic contact_type rand_contact();
      contact_type t;
      int m;
      m = ($urandom_range(0, 4) == 0) ? 2 : 0;
      t.v1 = rand_vec(m); t.v2 = rand_vec(m);
      t.a1 = rand_vec(m); t.a2 = rand_vec(m);
      t.p1 = rand_vec(m); t.p2 = rand_vec(m);
      t.n = rand_vec(($urandom_range(0, 4) == 0) ? 2 : 1);
      case ($urandom_range(0, 5))
         0: t.inv1 = 0;
         1: t.inv1 = INV_W'($urandom);
         default: t.inv1 = INV_W'($urandom_range(1, 200000));
      endcase
      case ($urandom_range(0, 5))
         0: t.inv2 = 0;
         1: t.inv2 = INV_W'($urandom);
         default: t.inv2 = INV_W'($urandom_range(1, 200000));
      endcase
      t.depth = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom)
                                            : DEPTH_W'($urandom_range(0, 3000)) - 500;
      t.bounce = ($urandom_range(0, 4) == 0) ? BOUNCE_W'($urandom)
                                             : BOUNCE_W'($urandom_range(0, 32768));
      t.present = $urandom_range(0, 3) != 0;
      return t;
   endfunction

   task automatic wait_drained();
      while (pending_contacts.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (QB + 20) @(posedge clock);
   endtask

   task automatic write_frame_step(logic [STEP_W-1:0] v);
      csr_frame_step <= v;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      frame_step_model = v;
   endtask

   initial begin
      contact_type t;
      logic [STEP_W-1:0] steps[5];
      steps = '{16'd0, 16'hFFFF, 16'd1092, 16'd30000, 16'd7};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed corners at reset frame step
      for (int k = 0; k < 24; k++) begin
         t = rand_contact();
         case (k)
            0: begin t.v1 = '1; t.v2 = '0; t.n = '1; t.bounce = 16'hFFFF; end
            1: begin t.v1 = {3{1'b0, {20{1'b1}}}}; t.n = t.v1; t.present = 1; end
            2: begin t.v1 = {3{1'b1, 20'b0}}; t.n = {3{1'b0, {20{1'b1}}}}; end
            3: begin t.inv1 = 0; t.inv2 = 0; end
            4: begin t.inv1 = 0; t.present = 0; end
            5: begin t.depth = 0; end
            6: begin t.depth = {1'b1, 20'b0}; end
            7: begin t.depth = {1'b0, {20{1'b1}}}; t.inv1 = '1; t.inv2 = '1; end
            8: begin t.v1 = t.v2; t.present = 1; end
            9: begin t.present = 0; t.v2 = '1; t.p2 = '1; t.a2 = '1; end
            10: begin t.bounce = 16'd32768; t.a1 = {3{1'b1, 20'b0}}; end
            11: begin t.bounce = 0; end
            12: begin t.p1 = {3{1'b0, {20{1'b1}}}}; t.depth = 21'd100000; end
            13: begin t.inv2 = '1; t.inv1 = 1; t.present = 1; end
            14: begin t.n = '0; end
            15: begin t.v1 = '1; t.v2 = '1; t.a1 = '1; t.a2 = '1;
                      t.p1 = '1; t.p2 = '1; t.n = '1; t.present = 1; end
            default: ;
         endcase
         pending_contacts.push_back(t);
      end
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         write_frame_step(steps[ph]);
         for (int k = 0; k < 170; k++) pending_contacts.push_back(rand_contact());
         // pause sender until everything is back
         if (ph == 2) begin
            while (pending_contacts.size() > 80) @(posedge clock);
            hold_off <= 1;
            while (start || expected_results.size() != 0) @(posedge clock);
            hold_off <= 0;
         end
      end
      wait_drained();
      $display("covered %0d contacts over 5 frame steps, %0d impulses, %0d pushes",
               results_seen, vel_hits, pos_hits);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule

// ===== particle_contact_resolver.f =====
rtl/pcr_pkg.sv
rtl/pcr_div.sv
rtl/particle_contact_resolver.sv
tb/tb.sv
